// File: rtl/core/rmf_pkg.sv
package rmf_pkg;

   // line store depth and the index that addresses it
   localparam int MaxWidth = 1024;
   localparam int ColBits  = $clog2(MaxWidth);

   // register field widths
   localparam int WidthBits  = 11;
   localparam int HeightBits = 13;
   localparam int RowBits    = 12;
   localparam int PixBits    = 24;
   localparam int ChanBits   = 8;
   localparam int NumChans   = 3;
   localparam int AddrBits   = 4;
   localparam int CsrBits    = 32;

   // register reset values
   localparam logic [WidthBits-1:0]  WIDTH_RESET  = WidthBits'(1024);
   localparam logic [HeightBits-1:0] HEIGHT_RESET = HeightBits'(1024);
   localparam logic                  FILTER_RESET = 1'b1;

   // register indexes (word address bits)
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_FILTER_ON    = 2'd2;

   typedef logic [ChanBits-1:0] sample_type;

   typedef struct packed {
      sample_type hi;
      sample_type md;
      sample_type lo;
   } trio_type;

   // per-word control that travels down the pipeline
   typedef struct packed {
      logic emit;
      logic interior;
      logic last;
   } tag_type;

   function automatic trio_type sort3(input sample_type a, input sample_type b,
                                      input sample_type c);
      sample_type x0;
      sample_type x1;
      sample_type x2;
      sample_type t;
      trio_type   r;
      x0 = a;
      x1 = b;
      x2 = c;
      if (x0 > x1) begin
         t  = x0;
         x0 = x1;
         x1 = t;
      end
      if (x1 > x2) begin
         t  = x1;
         x1 = x2;
         x2 = t;
      end
      if (x0 > x1) begin
         t  = x0;
         x0 = x1;
         x1 = t;
      end
      r.lo = x0;
      r.md = x1;
      r.hi = x2;
      return r;
   endfunction

   function automatic sample_type max3(input sample_type a, input sample_type b,
                                       input sample_type c);
      sample_type m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic sample_type min3(input sample_type a, input sample_type b,
                                       input sample_type c);
      sample_type m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic sample_type med3(input sample_type a, input sample_type b,
                                       input sample_type c);
      trio_type s;
      s = sort3(a, b, c);
      return s.md;
   endfunction

endpackage

// File: rtl/core/rgb_median_filter_3x3.sv
// 3x3 median filter for a raster stream of bgr pixels
//
// req channel: one word per pixel, tuser high marks a drain word that carries
// no pixel. after the last pixel of a frame, image_width+1 drain words push out
// the tail. a drain word during the pixel phase is dropped; a pixel word after
// the last pixel counts as drain and its data is discarded.
// rsp channel: one word per pixel, image_width+1 words behind the input, so
// the first image_width+1 words of a frame give no result. tlast marks the
// last pixel of the frame. interior pixels get the per-channel median of
// their 3x3 neighborhood when filter_on is set, border pixels pass through.
// throughput is one word per cycle unless a stalled rsp holds the pipeline; an accepted
// word reaches rsp through the line store read, window, column sort, merge and output stages.
// two line stores (1024 x 24 each) are read as a word is accepted and written back
// from the read-modify-write stage; a write to the column being read is forwarded.
// a stalled rsp only blocks req when a result is ready to enter the full
// output register, so bubbles keep draining into it.
// reset: width 1024, height 1024, filter on, frame position cleared; line
// store contents are undefined until written. any register write starts a
// new frame and must be done while the block is idle.
module rgb_median_filter_3x3 (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: in_blue [7:0], in_green [15:8], in_red [23:16]
   input  logic [rmf_pkg::PixBits-1:0]     req_tdata,
   // tuser: func (1 = drain word)
   input  logic                            req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: out_blue [7:0], out_green [15:8], out_red [23:16]
   output logic [rmf_pkg::PixBits-1:0]     rsp_tdata,
   // tlast: frame_end
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rmf_pkg::AddrBits-1:0]    csr_paddr,
   input  logic [rmf_pkg::CsrBits-1:0]     csr_pwdata,
   output logic [rmf_pkg::CsrBits-1:0]     csr_prdata,
   output logic                            csr_pready
);

   localparam int W  = rmf_pkg::WidthBits;
   localparam int H  = rmf_pkg::HeightBits;
   localparam int C  = rmf_pkg::ColBits;
   localparam int R  = rmf_pkg::RowBits;
   localparam int P  = rmf_pkg::PixBits;
   localparam int CB = rmf_pkg::ChanBits;
   localparam int NC = rmf_pkg::NumChans;

   // configuration registers
   logic [W-1:0] width_ff;
   logic [H-1:0] height_ff;
   logic         filter_ff;

   // frame position counters
   logic [W-1:0] in_col_ff,  in_col_in;
   logic [H-1:0] in_row_ff,  in_row_in;
   logic [C-1:0] out_col_ff, out_col_in;
   logic [R-1:0] out_row_ff, out_row_in;
   logic [W-1:0] fill_ff,    fill_in;

   // line stores: line0 delays one row, line1 two rows
   logic [P-1:0] line0_mem [rmf_pkg::MaxWidth];
   logic [P-1:0] line1_mem [rmf_pkg::MaxWidth];
   logic [P-1:0] top_rd_ff;
   logic [P-1:0] mid_rd_ff;

   // read-modify-write stage
   logic                 b_valid_ff;
   rmf_pkg::tag_type     b_tag_ff;
   logic [P-1:0]         b_px_ff;
   logic [C-1:0]         b_col_ff;
   logic                 fwd_ff;
   logic [P-1:0]         fwd_mid_ff;
   logic [P-1:0]         fwd_top_ff;
   logic [P-1:0]         mid_eff;
   logic [P-1:0]         top_eff;

   // window stage
   logic [P-1:0]         win_ff [9];
   rmf_pkg::tag_type     c_tag_ff;

   // column sort stage
   rmf_pkg::trio_type    sort_in [NC][3];
   rmf_pkg::trio_type    d_sort_ff [NC][3];
   logic [P-1:0]         d_center_ff;
   rmf_pkg::tag_type     d_tag_ff;

   // merge stage
   rmf_pkg::sample_type  e_max_ff [NC];
   rmf_pkg::sample_type  e_med_ff [NC];
   rmf_pkg::sample_type  e_min_ff [NC];
   logic [P-1:0]         e_center_ff;
   rmf_pkg::tag_type     e_tag_ff;

   // output register
   logic                 out_valid_ff;
   logic [P-1:0]         out_data_ff;
   logic [P-1:0]         out_data_in;
   logic                 out_last_ff;

   // front-end decode
   logic [W-1:0]         w_eff;
   logic [H-1:0]         h_eff;
   logic [W-1:0]         w_plus1;
   logic                 adv;
   logic                 accept;
   logic                 drain;
   logic                 proc;
   logic [P-1:0]         px_new;
   logic [W-1:0]         col_wide;
   logic [C-1:0]         col_new;
   logic [W-1:0]         in_col_inc;
   logic [W-1:0]         out_col_nx;
   logic [H-1:0]         out_row_nx;
   rmf_pkg::tag_type     tag_new;
   logic                 cfg_write;
   logic [1:0]           cfg_index;

   // the pipeline moves unless a result would land on a full, stalled output
   assign adv        = !(out_valid_ff && !rsp_tready && e_tag_ff.emit);
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   assign w_eff = (width_ff == '0) ? W'(1)
                : ((width_ff > W'(rmf_pkg::MaxWidth)) ? W'(rmf_pkg::MaxWidth) : width_ff);
   assign h_eff   = (height_ff == '0) ? H'(1) : height_ff;
   assign w_plus1 = w_eff + W'(1);

   assign drain  = in_row_ff >= h_eff;
   assign proc   = accept && (drain || !req_tuser);
   assign px_new = drain ? '0 : req_tdata;

   // drain words run the column past the width by at most one row
   assign col_wide = (in_col_ff >= w_eff) ? (in_col_ff - w_eff) : in_col_ff;
   assign col_new  = col_wide[C-1:0];

   assign in_col_inc = in_col_ff + W'(1);
   assign out_col_nx = {1'b0, out_col_ff} + W'(1);
   assign out_row_nx = {1'b0, out_row_ff} + H'(1);

   always_comb begin
      tag_new.emit     = proc && (fill_ff >= w_plus1);
      tag_new.interior = filter_ff && (out_row_ff != '0) && (out_row_nx < h_eff) &&
                         (out_col_ff != '0) && (out_col_nx < w_eff);
      tag_new.last     = (out_row_nx >= h_eff) && (out_col_nx >= w_eff);
   end

   // position counter update for one processed word
   always_comb begin
      in_col_in  = in_col_inc;
      in_row_in  = in_row_ff;
      fill_in    = (fill_ff < w_plus1) ? (fill_ff + W'(1)) : fill_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (!drain && (in_col_inc >= w_eff)) begin
         in_col_in = '0;
         in_row_in = in_row_ff + H'(1);
      end
      if (tag_new.emit) begin
         if (tag_new.last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            fill_in    = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (out_col_nx >= w_eff) begin
            out_col_in = '0;
            out_row_in = out_row_nx[R-1:0];
         end else begin
            out_col_in = out_col_nx[C-1:0];
         end
      end
   end

   // configuration port
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (cfg_index)
         rmf_pkg::REG_IMAGE_WIDTH:  csr_prdata = rmf_pkg::CsrBits'(width_ff);
         rmf_pkg::REG_IMAGE_HEIGHT: csr_prdata = rmf_pkg::CsrBits'(height_ff);
         rmf_pkg::REG_FILTER_ON:    csr_prdata = rmf_pkg::CsrBits'(filter_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // forwarding covers a write-back to the column read in the same cycle
   assign mid_eff = fwd_ff ? fwd_mid_ff : mid_rd_ff;
   assign top_eff = fwd_ff ? fwd_top_ff : top_rd_ff;

   // line store read ahead, write-back from the read-modify-write stage
   always_ff @(posedge clock) begin
      if (adv) begin
         top_rd_ff <= line1_mem[col_new];
         mid_rd_ff <= line0_mem[col_new];
         if (b_valid_ff) begin
            line0_mem[b_col_ff] <= b_px_ff;
            line1_mem[b_col_ff] <= mid_eff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rmf_pkg::WIDTH_RESET;
         height_ff    <= rmf_pkg::HEIGHT_RESET;
         filter_ff    <= rmf_pkg::FILTER_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         fill_ff      <= '0;
         b_valid_ff   <= 1'b0;
         b_tag_ff     <= '0;
         c_tag_ff     <= '0;
         d_tag_ff     <= '0;
         e_tag_ff     <= '0;
         fwd_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cfg_write) begin
            unique case (cfg_index)
               rmf_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[W-1:0];
               rmf_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[H-1:0];
               rmf_pkg::REG_FILTER_ON:    filter_ff <= csr_pwdata[0];
               default: ;
            endcase
            // a known register write restarts the frame
            if (cfg_index != 2'd3) begin
               in_col_ff  <= '0;
               in_row_ff  <= '0;
               out_col_ff <= '0;
               out_row_ff <= '0;
               fill_ff    <= '0;
            end
         end else if (proc) begin
            in_col_ff  <= in_col_in;
            in_row_ff  <= in_row_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
            fill_ff    <= fill_in;
         end
         if (adv) begin
            b_valid_ff <= proc;
            b_tag_ff   <= tag_new;
            c_tag_ff   <= b_tag_ff;
            d_tag_ff   <= c_tag_ff;
            e_tag_ff   <= d_tag_ff;
            fwd_ff     <= b_valid_ff && (b_col_ff == col_new);
         end
         if (adv && e_tag_ff.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // column sorts of the window, per channel
   always_comb begin
      for (int ch = 0; ch < NC; ch++) begin
         for (int cl = 0; cl < 3; cl++) begin
            sort_in[ch][cl] = rmf_pkg::sort3(win_ff[cl][ch*CB +: CB],
                                             win_ff[cl+3][ch*CB +: CB],
                                             win_ff[cl+6][ch*CB +: CB]);
         end
      end
   end

   // final median, or the center pixel for border and bypass
   always_comb begin
      for (int ch = 0; ch < NC; ch++) begin
         out_data_in[ch*CB +: CB] = e_tag_ff.interior
                                  ? rmf_pkg::med3(e_max_ff[ch], e_med_ff[ch], e_min_ff[ch])
                                  : e_center_ff[ch*CB +: CB];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (adv) begin
         b_px_ff    <= px_new;
         b_col_ff   <= col_new;
         fwd_mid_ff <= b_px_ff;
         fwd_top_ff <= mid_eff;
         if (b_valid_ff) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= top_eff;
            win_ff[3] <= win_ff[4];
            win_ff[4] <= win_ff[5];
            win_ff[5] <= mid_eff;
            win_ff[6] <= win_ff[7];
            win_ff[7] <= win_ff[8];
            win_ff[8] <= b_px_ff;
         end
         d_sort_ff   <= sort_in;
         d_center_ff <= win_ff[4];
         for (int ch = 0; ch < NC; ch++) begin
            e_max_ff[ch] <= rmf_pkg::max3(d_sort_ff[ch][0].lo, d_sort_ff[ch][1].lo,
                                          d_sort_ff[ch][2].lo);
            e_med_ff[ch] <= rmf_pkg::med3(d_sort_ff[ch][0].md, d_sort_ff[ch][1].md,
                                          d_sort_ff[ch][2].md);
            e_min_ff[ch] <= rmf_pkg::min3(d_sort_ff[ch][0].hi, d_sort_ff[ch][1].hi,
                                          d_sort_ff[ch][2].hi);
         end
         e_center_ff <= d_center_ff;
         if (e_tag_ff.emit) begin
            out_data_ff <= out_data_in;
            out_last_ff <= e_tag_ff.last;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import rmf_pkg::*;

   typedef logic [PixBits-1:0] pixel_t;

   // one filtered pixel as it should leave the rsp channel
   typedef struct packed {
      pixel_t pix;
      logic   last;
   } result_t;

   typedef enum logic {STEP_WRITE, STEP_WORD} step_kind_e;

   // one row of the directed script: a register write or a req word
   typedef struct packed {
      step_kind_e  kind;
      logic [1:0]  reg_index;
      logic [12:0] value;
      logic        drain;
      pixel_t      px;
      logic        typed;
      pixel_t      want_px;
      logic        want_last;
   } step_t;

   localparam bit FUNC_PIXEL = 1'b0;
   localparam bit FUNC_DRAIN = 1'b1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_WORDS = 1900;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pixel_t req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   pixel_t rsp_tdata;
   logic rsp_tlast;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [AddrBits-1:0] csr_paddr = '0;
   logic [CsrBits-1:0] csr_pwdata = '0;
   logic [CsrBits-1:0] csr_prdata;
   logic csr_pready;

   // register copies held by the predictor
   logic [WidthBits-1:0] cfg_width = WIDTH_RESET;
   logic [HeightBits-1:0] cfg_height = HEIGHT_RESET;
   logic cfg_filter = FILTER_RESET;

   // predictor state: two row delays, the 3x3 window, frame positions
   pixel_t near_line [MaxWidth];
   pixel_t far_line [MaxWidth];
   pixel_t window_px [9];
   int in_col = 0;
   int in_row = 0;
   int out_col = 0;
   int out_row = 0;

   result_t expected_pixels [$];
   int mismatches = 0;
   int cycle_count = 0;
   int counted_words = 0;

   rgb_median_filter_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // cycle counter and the hard stop
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // both sides pause about 35 times in 100, except in one quiet stretch
   function automatic bit idle_roll();
      if (cycle_count >= 3000 && cycle_count < 4500) return 1'b0;
      return $urandom_range(99) < 35;
   endfunction

   // rsp back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_tready <= !idle_roll();
   end

   // widths out of range behave as their nearest legal value
   function automatic int stream_width(input int value);
      if (value == 0) return 1;
      if (value > MaxWidth) return MaxWidth;
      return value;
   endfunction

   function automatic int stream_height(input int value);
      return (value == 0) ? 1 : value;
   endfunction

   function automatic void clear_positions();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   // advance the window by one accepted word; returns 1 when a pixel comes out
   function automatic bit median_window_step(input bit drain, input pixel_t px,
                                             output result_t res);
      int cols;
      int rows;
      int col;
      int lin;
      int i;
      int j;
      int ch;
      bit draining;
      pixel_t din;
      pixel_t top;
      pixel_t mid;
      logic [7:0] samples [9];
      logic [7:0] key;
      cols = stream_width(cfg_width);
      rows = stream_height(cfg_height);
      res = '0;
      draining = (in_row >= rows);
      // a drain word before the last pixel of the frame does nothing
      if (!draining && drain) return 1'b0;
      // once all pixels are in, any word is a drain and carries zeros
      din = draining ? '0 : px;
      col = in_col % cols;
      top = far_line[col];
      mid = near_line[col];
      far_line[col] = mid;
      near_line[col] = din;
      for (i = 0; i < 3; i++) begin
         window_px[i*3] = window_px[i*3+1];
         window_px[i*3+1] = window_px[i*3+2];
      end
      window_px[2] = top;
      window_px[5] = mid;
      window_px[8] = din;
      lin = in_row * cols + in_col;
      in_col++;
      if (!draining && in_col >= cols) begin
         in_col = 0;
         in_row++;
      end
      // nothing comes out until a row and one pixel have gone by
      if (lin < cols + 1) return 1'b0;
      res.pix = window_px[4];
      if (cfg_filter && out_row >= 1 && out_row + 1 < rows &&
          out_col >= 1 && out_col + 1 < cols) begin
         for (ch = 0; ch < NumChans; ch++) begin
            // insertion sort of one channel, fifth smallest is the median
            for (i = 0; i < 9; i++) begin
               key = window_px[i][ch*ChanBits +: ChanBits];
               j = i;
               while (j > 0 && samples[j-1] > key) begin
                  samples[j] = samples[j-1];
                  j--;
               end
               samples[j] = key;
            end
            res.pix[ch*ChanBits +: ChanBits] = samples[4];
         end
      end
      res.last = (out_row + 1 >= rows && out_col + 1 >= cols);
      if (res.last) begin
         clear_positions();
      end else begin
         out_col++;
         if (out_col >= cols) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1'b1;
   endfunction

   // rsp checker: each word against the oldest expected pixel
   always @(posedge clock) begin : rsp_check
      result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $error("rsp word with nothing expected: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== want.pix[7:0]) begin
               $error("out_blue: expected %h, got %h", want.pix[7:0], rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tdata[15:8] !== want.pix[15:8]) begin
               $error("out_green: expected %h, got %h", want.pix[15:8], rsp_tdata[15:8]);
               mismatches++;
            end
            if (rsp_tdata[23:16] !== want.pix[23:16]) begin
               $error("out_red: expected %h, got %h", want.pix[23:16], rsp_tdata[23:16]);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("frame_end: expected %b, got %b", want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // mostly random pixels, some with saturated or empty channels
   function automatic pixel_t rand_pixel();
      pixel_t p;
      int ch;
      p = pixel_t'($urandom);
      if ($urandom_range(99) < 20) begin
         for (ch = 0; ch < NumChans; ch++) begin
            case ($urandom_range(2))
               0: p[ch*ChanBits +: ChanBits] = 8'h00;
               1: p[ch*ChanBits +: ChanBits] = 8'hff;
               default: ;
            endcase
         end
      end
      return p;
   endfunction

   // one req word; called and returning at a falling edge
   task automatic push_word(input bit drain, input pixel_t px, input bit typed,
                            input result_t typed_want);
      result_t got;
      if (idle_roll()) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while (idle_roll());
      end
      req_tvalid <= 1'b1;
      req_tuser <= drain;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // typed rows carry the expected value given in the script in place of the predictor's
      if (median_window_step(drain, px, got))
         expected_pixels.push_back(typed ? typed_want : got);
      @(negedge clock);
   endtask

   // hold the sender until every expected pixel has come, then some settle time
   task automatic wait_for_results(input int extra);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // apb write: setup, then access; the register takes it at the access edge
   task automatic write_reg(input logic [1:0] idx, input int value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_IMAGE_WIDTH: cfg_width = value[WidthBits-1:0];
         REG_IMAGE_HEIGHT: cfg_height = value[HeightBits-1:0];
         REG_FILTER_ON: cfg_filter = value[0];
         default: ;
      endcase
      // any write restarts the frame
      clear_positions();
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // one frame: pixels with stray drain words, then the drain tail;
   // a cut frame stops after that many pixels and is left unfinished
   task automatic send_frame(input int cols, input int rows, input int cut);
      int total;
      int pause_at;
      int k;
      total = (cut >= 0) ? cut : cols * rows;
      pause_at = ($urandom_range(99) < 8) ? $urandom_range(total) : -1;
      for (k = 0; k < total; k++) begin
         if (k == pause_at) wait_for_results(0);
         // a drain word in the pixel phase is dropped by the block
         if ($urandom_range(99) < 4) push_word(FUNC_DRAIN, rand_pixel(), 1'b0, '0);
         push_word(FUNC_PIXEL, rand_pixel(), 1'b0, '0);
         counted_words++;
      end
      if (cut >= 0) return;
      for (k = 0; k <= cols; k++) begin
         // a pixel word in the drain phase counts as a drain
         if ($urandom_range(99) < 20) push_word(FUNC_PIXEL, rand_pixel(), 1'b0, '0);
         else push_word(FUNC_DRAIN, rand_pixel(), 1'b0, '0);
         counted_words++;
      end
      if ($urandom_range(99) < 25) push_word(FUNC_DRAIN, rand_pixel(), 1'b0, '0);
   endtask

   // new register setting on an idle block, then whole or cut frames
   task automatic run_phase(input int width_val, input int height_val, input bit filt,
                            input int frames, input int cut);
      wait_for_results(SETTLE_CYCLES);
      write_reg(REG_IMAGE_WIDTH, width_val);
      write_reg(REG_IMAGE_HEIGHT, height_val);
      write_reg(REG_FILTER_ON, filt);
      repeat (frames) send_frame(stream_width(width_val), stream_height(height_val), cut);
   endtask

   // directed script: degenerate 1x1 frames, drain corner cases, then a 3x3 frame
   step_t plan [25] = '{
      '{STEP_WRITE, REG_IMAGE_WIDTH,  13'd0, 1'b0, 24'h0, 1'b0, 24'h0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd0, 1'b0, 24'h0, 1'b0, 24'h0, 1'b0},
      // single white pixel comes back two words later as the frame end
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'hffffff, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_DRAIN, 24'h0, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_DRAIN, 24'h0, 1'b1, 24'hffffff, 1'b1},
      // drain before any pixel of the next frame is dropped
      '{STEP_WORD, 2'd0, 13'd0, FUNC_DRAIN, 24'habcdef, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
      // pixel after the frame is full acts as drain, its data is lost
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'h5a3cc3, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_DRAIN, 24'h0, 1'b1, 24'h000000, 1'b1},
      '{STEP_WRITE, REG_IMAGE_WIDTH,  13'd3, 1'b0, 24'h0, 1'b0, 24'h0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd3, 1'b0, 24'h0, 1'b0, 24'h0, 1'b0},
      '{STEP_WRITE, REG_FILTER_ON,    13'd1, 1'b0, 24'h0, 1'b0, 24'h0, 1'b0},
      // 3x3 frame: only the center is interior
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'hff0000, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'h00ff00, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'h0000ff, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'hffffff, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'h80807f, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'h01fe7f, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'hfe017f, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_PIXEL, 24'h7f7f80, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_DRAIN, 24'h0, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_DRAIN, 24'h0, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_DRAIN, 24'h0, 1'b0, 24'h0, 1'b0},
      '{STEP_WORD, 2'd0, 13'd0, FUNC_DRAIN, 24'h0, 1'b0, 24'h0, 1'b0}
   };

   initial begin : stimulus
      int n;
      int w_val;
      int h_val;
      int cut;
      for (n = 0; n < MaxWidth; n++) begin
         near_line[n] = '0;
         far_line[n] = '0;
      end
      for (n = 0; n < 9; n++) window_px[n] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset setting: 1024 wide, first row pass-through, frame left unfinished
      send_frame(stream_width(cfg_width), stream_height(cfg_height), MaxWidth + 3);

      for (n = 0; n < $size(plan); n++) begin
         if (plan[n].kind == STEP_WRITE) begin
            wait_for_results(SETTLE_CYCLES);
            write_reg(plan[n].reg_index, plan[n].value);
         end else begin
            push_word(plan[n].drain, plan[n].px, plan[n].typed,
                      '{plan[n].want_px, plan[n].want_last});
         end
      end

      // widest width then narrow ones, all at the tallest height, frames cut short
      run_phase(2047, 8191, 1'b1, 1, MaxWidth + 6);
      run_phase(5, 8191, 1'b1, 1, 60);
      run_phase(4, 8191, 1'b0, 1, 30);

      counted_words = 0;
      while (counted_words < RANDOM_WORDS) begin
         case ($urandom_range(19))
            0: w_val = 0;
            1: w_val = 1;
            2: w_val = 2;
            3: w_val = $urandom_range(32, 11);
            default: w_val = $urandom_range(10, 3);
         endcase
         case ($urandom_range(19))
            0, 1: h_val = 0;
            2: h_val = 1;
            default: h_val = $urandom_range((w_val > 10) ? 3 : 6, 2);
         endcase
         cut = -1;
         if ($urandom_range(99) < 10)
            cut = $urandom_range(stream_width(w_val) * stream_height(h_val));
         run_phase(w_val, h_val, $urandom_range(99) < 70,
                   (cut >= 0) ? 1 : $urandom_range(3, 1), cut);
      end

      wait_for_results(2 * SETTLE_CYCLES);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
